>>> design/mea_pkg.sv
// ----------------------------------------------------------------------------
// mea_pkg
// Shared types and codes for the 6502 effective address unit: item
// structures, transfer kinds, addressing mode codes and sequencer phases.
// ----------------------------------------------------------------------------
package mea_pkg;

    // field widths
    localparam int ModeW = 4;
    localparam int AddrW = 16;
    localparam int ByteW = 8;

    // input transfer kinds (tuser)
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // result kinds (tuser)
    localparam logic RES_REQ  = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // addressing mode codes
    localparam logic [ModeW-1:0] MODE_IMP  = 4'd0;
    localparam logic [ModeW-1:0] MODE_ACC  = 4'd1;
    localparam logic [ModeW-1:0] MODE_IMM  = 4'd2;
    localparam logic [ModeW-1:0] MODE_ZP   = 4'd3;
    localparam logic [ModeW-1:0] MODE_ZPX  = 4'd4;
    localparam logic [ModeW-1:0] MODE_ZPY  = 4'd5;
    localparam logic [ModeW-1:0] MODE_ABS  = 4'd6;
    localparam logic [ModeW-1:0] MODE_ABSX = 4'd7;
    localparam logic [ModeW-1:0] MODE_ABSY = 4'd8;
    localparam logic [ModeW-1:0] MODE_IND  = 4'd9;
    localparam logic [ModeW-1:0] MODE_INDX = 4'd10;
    localparam logic [ModeW-1:0] MODE_INDY = 4'd11;
    localparam logic [ModeW-1:0] MODE_REL  = 4'd12;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_OP_LO  = 3'd1,
        PH_OP_HI  = 3'd2,
        PH_PTR_LO = 3'd3,
        PH_PTR_HI = 3'd4
    } phase_t;

    // one input item
    typedef struct packed {
        logic             kind;
        logic [ModeW-1:0] mode;
        logic [AddrW-1:0] pc_in;
        logic [ByteW-1:0] index_x;
        logic [ByteW-1:0] index_y;
        logic [ByteW-1:0] read_data;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic             result_kind;
        logic [AddrW-1:0] address;
        logic [AddrW-1:0] next_pc;
        logic             page_crossed;
    } res_item_t;

endpackage

>>> design/mea_in_reg.sv
// ----------------------------------------------------------------------------
// mea_in_reg
// Input register: holds one accepted item until the sequencer consumes it.
// ----------------------------------------------------------------------------
module mea_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mea_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              held_valid,
    output mea_pkg::in_item_t held_item
);
    import mea_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // free when empty or when the held item moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> design/mea_sequencer.sv
// ----------------------------------------------------------------------------
// mea_sequencer
// Address sequencer: one step per consumed item, holding the latched
// operands and the fetch phase, and producing at most one result per step.
// ----------------------------------------------------------------------------
module mea_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  mea_pkg::in_item_t  item,
    output logic               res_valid,
    output mea_pkg::res_item_t res
);
    import mea_pkg::*;

    phase_t           phase_reg,    phase_next;
    logic [ModeW-1:0] mode_reg,     mode_next;
    logic [AddrW-1:0] pc_reg,       pc_next;
    logic [ByteW-1:0] x_reg,        x_next;
    logic [ByteW-1:0] y_reg,        y_next;
    logic [AddrW-1:0] pointer_reg,  pointer_next;
    logic [ByteW-1:0] low_reg,      low_next;

    logic [ByteW-1:0] rd;
    logic [AddrW-1:0] pc1;
    logic [AddrW-1:0] pc2;
    logic [AddrW-1:0] word;
    logic [ByteW-1:0] ptr_inc;

    function automatic res_item_t build(input logic kind, input logic [AddrW-1:0] addr,
                                        input logic [AddrW-1:0] npc, input logic pg);
        res_item_t r;
        r.result_kind  = kind;
        r.address      = addr;
        r.next_pc      = npc;
        r.page_crossed = pg;
        return r;
    endfunction

    // base plus index with page-cross detect
    function automatic res_item_t indexed(input logic [AddrW-1:0] base,
                                          input logic [ByteW-1:0] idx,
                                          input logic [AddrW-1:0] npc);
        logic [AddrW-1:0] sum;
        sum = base + {{(AddrW-ByteW){1'b0}}, idx};
        return build(RES_DONE, sum, npc, base[AddrW-1:ByteW] != sum[AddrW-1:ByteW]);
    endfunction

    // shared step terms
    assign rd      = item.read_data;
    assign pc1     = pc_reg + 16'd1;
    assign pc2     = pc_reg + 16'd2;
    assign word    = {rd, low_reg};
    assign ptr_inc = pointer_reg[ByteW-1:0] + 8'd1;

    // next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        mode_next    = mode_reg;
        pc_next      = pc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        pointer_next = pointer_reg;
        low_next     = low_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (fire)
        begin
            if (item.kind == KIND_START)
            begin
                mode_next  = item.mode;
                pc_next    = item.pc_in;
                x_next     = item.index_x;
                y_next     = item.index_y;
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                if (item.mode == MODE_IMM)
                begin
                    res = build(RES_DONE, item.pc_in, item.pc_in + 16'd1, 1'b0);
                end
                else if (item.mode < MODE_IMM || item.mode > MODE_REL)
                begin
                    // implied, accumulator and undefined codes
                    res = build(RES_DONE, '0, item.pc_in, 1'b0);
                end
                else
                begin
                    phase_next = PH_OP_LO;
                    res        = build(RES_REQ, item.pc_in, '0, 1'b0);
                end
            end
            else
            begin
                phase_next = PH_IDLE;
                case (phase_reg)
                    PH_OP_LO:
                    begin
                        res_valid = 1'b1;
                        case (mode_reg)
                            MODE_ZP:
                                res = build(RES_DONE, {8'h00, rd}, pc1, 1'b0);
                            MODE_ZPX:
                                res = build(RES_DONE, {8'h00, rd + x_reg}, pc1, 1'b0);
                            MODE_ZPY:
                                res = build(RES_DONE, {8'h00, rd + y_reg}, pc1, 1'b0);
                            MODE_REL:
                                res = build(RES_DONE, pc1 + {{8{rd[7]}}, rd}, pc1, 1'b0);
                            MODE_INDX:
                            begin
                                pointer_next = {8'h00, rd + x_reg};
                                phase_next   = PH_PTR_LO;
                                res          = build(RES_REQ, {8'h00, rd + x_reg}, '0, 1'b0);
                            end
                            MODE_INDY:
                            begin
                                pointer_next = {8'h00, rd};
                                phase_next   = PH_PTR_LO;
                                res          = build(RES_REQ, {8'h00, rd}, '0, 1'b0);
                            end
                            default:
                            begin
                                low_next   = rd;
                                phase_next = PH_OP_HI;
                                res        = build(RES_REQ, pc1, '0, 1'b0);
                            end
                        endcase
                    end
                    PH_OP_HI:
                    begin
                        res_valid = 1'b1;
                        if (mode_reg == MODE_ABSX)
                        begin
                            res = indexed(word, x_reg, pc2);
                        end
                        else if (mode_reg == MODE_ABSY)
                        begin
                            res = indexed(word, y_reg, pc2);
                        end
                        else if (mode_reg == MODE_IND)
                        begin
                            pointer_next = word;
                            phase_next   = PH_PTR_LO;
                            res          = build(RES_REQ, word, '0, 1'b0);
                        end
                        else
                        begin
                            res = build(RES_DONE, word, pc2, 1'b0);
                        end
                    end
                    PH_PTR_LO:
                    begin
                        res_valid  = 1'b1;
                        low_next   = rd;
                        phase_next = PH_PTR_HI;
                        // pointer high byte stays in the same page
                        if (mode_reg == MODE_IND)
                        begin
                            res = build(RES_REQ, {pointer_reg[AddrW-1:ByteW], ptr_inc}, '0,
                                        1'b0);
                        end
                        else
                        begin
                            res = build(RES_REQ, {8'h00, ptr_inc}, '0, 1'b0);
                        end
                    end
                    PH_PTR_HI:
                    begin
                        res_valid = 1'b1;
                        if (mode_reg == MODE_IND)
                        begin
                            res = build(RES_DONE, word, pc2, 1'b0);
                        end
                        else if (mode_reg == MODE_INDY)
                        begin
                            res = indexed(word, y_reg, pc1);
                        end
                        else
                        begin
                            res = build(RES_DONE, word, pc1, 1'b0);
                        end
                    end
                    default:
                    begin
                        // read data while idle is dropped
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            mode_reg    <= '0;
            pc_reg      <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            pointer_reg <= '0;
            low_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            mode_reg    <= mode_next;
            pc_reg      <= pc_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            pointer_reg <= pointer_next;
            low_reg     <= low_next;
        end
    end

    // a start always answers at once
    a_start_answers: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == KIND_START |-> res_valid)
        else $error("start item gave no result");

    // stray read data gives nothing
    a_idle_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == KIND_DATA && phase_reg == PH_IDLE |-> !res_valid)
        else $error("read data while idle gave a result");

    // immediate finishes in one step
    a_imm_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == KIND_START && item.mode == MODE_IMM |=> phase_reg == PH_IDLE)
        else $error("immediate mode left the sequencer busy");

    // second operand byte only for absolute-type modes
    a_op_hi_mode: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OP_HI |-> mode_reg == MODE_ABS || mode_reg == MODE_ABSX ||
                                  mode_reg == MODE_ABSY || mode_reg == MODE_IND)
        else $error("operand high fetch in a one-byte mode");

    // a request never carries finish fields
    a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == RES_REQ |-> res.next_pc == '0 && !res.page_crossed)
        else $error("read request with finish fields set");

endmodule

>>> design/mea_out_reg.sv
// ----------------------------------------------------------------------------
// mea_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mea_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  mea_pkg::res_item_t load_item,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output mea_pkg::res_item_t out_item
);
    import mea_pkg::*;

    logic      valid_reg;
    res_item_t item_reg;

    // can take a new result when empty or draining this cycle
    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && room)
        begin
            item_reg <= load_item;
        end
    end

endmodule

>>> design/mos6502_effective_address_unit.sv
// ----------------------------------------------------------------------------
// mos6502_effective_address_unit
// Effective address unit for the thirteen 6502 addressing modes.
// ----------------------------------------------------------------------------
// A start transfer (tuser 0) brings mode, PC and X/Y; the unit answers with
// either a finished address (result tuser 1) or a byte read request (result
// tuser 0). Each read request must be answered by a read-data transfer
// (tuser 1) carrying the byte; read data with no calculation running is
// dropped, and a new start abandons any calculation in progress. The unit
// takes one transfer per cycle while the result register has room; each accepted
// transfer waits in the input register, then one step of the address sequencer
// (a 16-bit add and a mux) puts its result, if any, into the result register.
// ----------------------------------------------------------------------------
module mos6502_effective_address_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mode, pc_in, index_x, index_y, read_data
    input  logic [0:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // address, next_pc, page_crossed
    output logic [0:0]  m_axis_tuser    // result_kind
);
    import mea_pkg::*;

    in_item_t  in_item;
    in_item_t  held_item;
    res_item_t res;
    res_item_t out_item;
    logic      held_valid;
    logic      advance;
    logic      res_valid;
    logic      room;

    // unpack the input transfer
    assign in_item.kind      = s_axis_tuser[0];
    assign in_item.mode      = s_axis_tdata[3:0];
    assign in_item.pc_in     = s_axis_tdata[19:4];
    assign in_item.index_x   = s_axis_tdata[27:20];
    assign in_item.index_y   = s_axis_tdata[35:28];
    assign in_item.read_data = s_axis_tdata[43:36];

    // the held item steps when the result register can take its answer
    assign advance = held_valid && room;

    mea_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    mea_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    mea_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_item (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    // pack the result transfer
    assign m_axis_tuser[0]     = out_item.result_kind;
    assign m_axis_tdata[15:0]  = out_item.address;
    assign m_axis_tdata[31:16] = out_item.next_pc;
    assign m_axis_tdata[32]    = out_item.page_crossed;
    assign m_axis_tdata[39:33] = '0;

endmodule

>>> dv/mea_address_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mea_address_checker
// Watches both stream channels of the effective address unit. Every accepted
// input transfer is run through a local model of the address sequencer, and
// the results it should cause are queued. Every accepted result transfer is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module mea_address_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mode, pc_in, index_x, index_y, read_data
    input  logic [0:0]  s_axis_tuser,   // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // address, next_pc, page_crossed
    input  logic [0:0]  m_axis_tuser,   // result_kind
    output int          mismatches,
    output int          outstanding
);
    import mea_pkg::*;

    // model copy of the sequencer state
    phase_t           seq_phase;
    logic [ModeW-1:0] mode_q;
    logic [AddrW-1:0] pc_q;
    logic [ByteW-1:0] x_q;
    logic [ByteW-1:0] y_q;
    logic [AddrW-1:0] ptr_q;
    logic [ByteW-1:0] lo_q;

    // results still owed by the unit, oldest first
    res_item_t expected_results[$];

    function automatic res_item_t make_done(input logic [AddrW-1:0] addr,
                                            input logic [AddrW-1:0] npc,
                                            input logic pg);
        res_item_t r;
        r.result_kind  = RES_DONE;
        r.address      = addr;
        r.next_pc      = npc;
        r.page_crossed = pg;
        return r;
    endfunction

    function automatic res_item_t make_read(input logic [AddrW-1:0] addr);
        res_item_t r;
        r.result_kind  = RES_REQ;
        r.address      = addr;
        r.next_pc      = '0;
        r.page_crossed = 1'b0;
        return r;
    endfunction

    // base plus index, flagging a move into another page
    function automatic res_item_t make_indexed(input logic [AddrW-1:0] base,
                                               input logic [ByteW-1:0] idx,
                                               input logic [AddrW-1:0] npc);
        logic [AddrW-1:0] sum;
        sum = base + {8'h00, idx};
        return make_done(sum, npc, base[15:8] != sum[15:8]);
    endfunction

    // one step of the address sequencer; returns 1 when a result is produced
    function automatic logic predict_address(input in_item_t it, output res_item_t res);
        logic [AddrW-1:0] pc1;
        logic [AddrW-1:0] pc2;
        logic [AddrW-1:0] word;
        logic [AddrW-1:0] offset;
        logic [ByteW-1:0] b;
        logic [ByteW-1:0] zp_x;
        logic [ByteW-1:0] zp_y;
        logic [ByteW-1:0] ptr_next;
        b        = it.read_data;
        pc1      = pc_q + 16'd1;
        pc2      = pc_q + 16'd2;
        word     = {b, lo_q};
        zp_x     = b + x_q;
        zp_y     = b + y_q;
        ptr_next = ptr_q[7:0] + 8'd1;
        res      = '0;

        // start transfer: latch operands, finish at once or ask for the first byte
        if (it.kind == KIND_START)
        begin
            mode_q    = it.mode;
            pc_q      = it.pc_in;
            x_q       = it.index_x;
            y_q       = it.index_y;
            seq_phase = PH_IDLE;
            if (it.mode == MODE_IMM)
            begin
                res = make_done(it.pc_in, it.pc_in + 16'd1, 1'b0);
            end
            else if (it.mode < MODE_IMM || it.mode > MODE_REL)
            begin
                res = make_done('0, it.pc_in, 1'b0);
            end
            else
            begin
                seq_phase = PH_OP_LO;
                res       = make_read(it.pc_in);
            end
            return 1'b1;
        end

        // read data transfer
        case (seq_phase)
            PH_OP_LO:
            begin
                seq_phase = PH_IDLE;
                case (mode_q)
                    MODE_ZP:   res = make_done({8'h00, b}, pc1, 1'b0);
                    MODE_ZPX:  res = make_done({8'h00, zp_x}, pc1, 1'b0);
                    MODE_ZPY:  res = make_done({8'h00, zp_y}, pc1, 1'b0);
                    MODE_REL:
                    begin
                        offset = {{8{b[7]}}, b};
                        res    = make_done(pc1 + offset, pc1, 1'b0);
                    end
                    MODE_INDX:
                    begin
                        ptr_q     = {8'h00, zp_x};
                        seq_phase = PH_PTR_LO;
                        res       = make_read(ptr_q);
                    end
                    MODE_INDY:
                    begin
                        ptr_q     = {8'h00, b};
                        seq_phase = PH_PTR_LO;
                        res       = make_read(ptr_q);
                    end
                    default:
                    begin
                        lo_q      = b;
                        seq_phase = PH_OP_HI;
                        res       = make_read(pc1);
                    end
                endcase
                return 1'b1;
            end
            PH_OP_HI:
            begin
                seq_phase = PH_IDLE;
                if (mode_q == MODE_ABSX)
                begin
                    res = make_indexed(word, x_q, pc2);
                end
                else if (mode_q == MODE_ABSY)
                begin
                    res = make_indexed(word, y_q, pc2);
                end
                else if (mode_q == MODE_IND)
                begin
                    ptr_q     = word;
                    seq_phase = PH_PTR_LO;
                    res       = make_read(ptr_q);
                end
                else
                begin
                    res = make_done(word, pc2, 1'b0);
                end
                return 1'b1;
            end
            PH_PTR_LO:
            begin
                // pointer high byte comes from the same page (indirect jump)
                // or from page zero (indexed indirect modes)
                lo_q      = b;
                seq_phase = PH_PTR_HI;
                if (mode_q == MODE_IND)
                    res = make_read({ptr_q[15:8], ptr_next});
                else
                    res = make_read({8'h00, ptr_next});
                return 1'b1;
            end
            PH_PTR_HI:
            begin
                seq_phase = PH_IDLE;
                if (mode_q == MODE_IND)
                    res = make_done(word, pc2, 1'b0);
                else if (mode_q == MODE_INDY)
                    res = make_indexed(word, y_q, pc1);
                else
                    res = make_done(word, pc1, 1'b0);
                return 1'b1;
            end
            default:
            begin
                // read data with nothing running is dropped
                seq_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [AddrW-1:0] want,
                               input logic [AddrW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    // compare result transfers first, then queue what input transfers cause
    always @(posedge clk or negedge rst_n)
    begin
        in_item_t  item;
        res_item_t want;
        res_item_t got;
        res_item_t predicted;
        if (!rst_n)
        begin
            seq_phase = PH_IDLE;
            mode_q    = '0;
            pc_q      = '0;
            x_q       = '0;
            y_q       = '0;
            ptr_q     = '0;
            lo_q      = '0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.result_kind  = m_axis_tuser[0];
                got.address      = m_axis_tdata[15:0];
                got.next_pc      = m_axis_tdata[31:16];
                got.page_crossed = m_axis_tdata[32];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", AddrW'(want.result_kind),
                                AddrW'(got.result_kind));
                    check_field("address", want.address, got.address);
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("page_crossed", AddrW'(want.page_crossed),
                                AddrW'(got.page_crossed));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                item.kind      = s_axis_tuser[0];
                item.mode      = s_axis_tdata[3:0];
                item.pc_in     = s_axis_tdata[19:4];
                item.index_x   = s_axis_tdata[27:20];
                item.index_y   = s_axis_tdata[35:28];
                item.read_data = s_axis_tdata[43:36];
                if (predict_address(item, predicted))
                    expected_results.push_back(predicted);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> dv/tb_mos6502_effective_address_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mos6502_effective_address_unit
// Drives start and read-data transfers into the effective address unit and
// leaves prediction and comparison to the checker. A directed pass covers
// each addressing special case, then random instruction sequences run under
// several sender idle and receiver stall mixes, with one long receiver
// hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb_mos6502_effective_address_unit;
    import mea_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 8;
    localparam int TIMEOUT_NS  = 5_000_000;

    // mode code outside the defined set
    localparam logic [ModeW-1:0] MODE_UNUSED = 4'hF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // mode, pc_in, index_x, index_y, read_data
    logic [0:0]  s_axis_tuser = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // address, next_pc, page_crossed
    logic [0:0]  m_axis_tuser;        // result_kind

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    mos6502_effective_address_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mea_address_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // biased toward the values that make pages and zero page wrap
    function automatic logic [ByteW-1:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'hFF;
            1:       return 8'h00;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return ByteW'($urandom);
        endcase
    endfunction

    function automatic logic [AddrW-1:0] pick_pc();
        case ($urandom_range(9))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2:       return {8'($urandom), 8'hFF};
            default: return AddrW'($urandom);
        endcase
    endfunction

    // operand and pointer bytes each mode asks for
    function automatic int reads_for(input logic [ModeW-1:0] mode);
        case (mode)
            MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL: return 1;
            MODE_ABS, MODE_ABSX, MODE_ABSY:        return 2;
            MODE_INDX, MODE_INDY:                  return 3;
            MODE_IND:                              return 4;
            default:                               return 0;
        endcase
    endfunction

    // offer one transfer, idling first at the current rate
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {4'h0, it.read_data, it.index_y, it.index_x, it.pc_in, it.mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_start(input logic [ModeW-1:0] mode, input logic [AddrW-1:0] pc,
                              input logic [ByteW-1:0] x, input logic [ByteW-1:0] y);
        in_item_t it;
        it.kind      = KIND_START;
        it.mode      = mode;
        it.pc_in     = pc;
        it.index_x   = x;
        it.index_y   = y;
        it.read_data = ByteW'($urandom);
        send_item(it);
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b);
        in_item_t it;
        it.kind      = KIND_DATA;
        it.mode      = ModeW'($urandom);
        it.pc_in     = AddrW'($urandom);
        it.index_x   = ByteW'($urandom);
        it.index_y   = ByteW'($urandom);
        it.read_data = b;
        send_item(it);
    endtask

    // stop offering and wait for every owed result, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random instruction sequences, some cut short, plus stray read data
    task automatic run_random(input int target);
        int               sent;
        int               pick;
        int               n;
        logic [ModeW-1:0] mode;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                send_byte(pick_byte());
            end
            else
            begin
                if (pick < 12)
                    mode = ModeW'($urandom_range(15, 0));
                else
                    mode = ModeW'($urandom_range(MODE_REL, MODE_ZP));
                n = reads_for(mode);
                if (pick < 20 && n > 0)
                    n = $urandom_range(n - 1, 0);
                send_start(mode, pick_pc(), pick_byte(), pick_byte());
                sent++;
                repeat (n)
                begin
                    send_byte(pick_byte());
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        run_random(target);
        drain_results();
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // immediate finishes, unknown mode, read data while idle
        send_start(MODE_IMP, 16'hFFFF, 8'h00, 8'hFF);
        send_start(MODE_IMM, 16'hFFFF, 8'hFF, 8'h00);
        send_start(MODE_UNUSED, 16'h0000, 8'hFF, 8'hFF);
        send_byte(8'h5A);
        // zero page index wraps within page zero
        send_start(MODE_ZPX, 16'h1234, 8'hFF, 8'h00);
        send_byte(8'hFF);
        // negative branch offset with program counter wrap
        send_start(MODE_REL, 16'hFFFF, 8'h00, 8'h00);
        send_byte(8'h80);
        // absolute indexed crossing a page
        send_start(MODE_ABSX, 16'h2000, 8'h20, 8'h00);
        send_byte(8'hF0);
        send_byte(8'h12);
        // indirect jump with pointer at a page end
        send_start(MODE_IND, 16'hC000, 8'h00, 8'h00);
        send_byte(8'hFF);
        send_byte(8'h10);
        send_byte(8'h34);
        send_byte(8'h12);
        // (zp,X) pointer wraps in page zero
        send_start(MODE_INDX, 16'h0400, 8'h80, 8'h00);
        send_byte(8'h7F);
        send_byte(8'hCD);
        send_byte(8'hAB);
        // start while busy, then (zp),Y with pointer wrap and page cross
        send_start(MODE_ABS, 16'h8000, 8'h00, 8'h00);
        send_byte(8'h11);
        send_start(MODE_INDY, 16'h0600, 8'h00, 8'hFF);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h20);
        drain_results();

        // random traffic under different idle and stall mixes
        run_phase(0, 0, 140);
        run_phase(77, 0, 140);
        run_phase(0, 77, 140);
        run_phase(27, 27, 140);

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        run_random(40);
        drain_results();

        if (mismatches == 0 && outstanding == 0)
            $display("PASS mos6502_effective_address_unit");
        else
            $display("FAIL mos6502_effective_address_unit");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL mos6502_effective_address_unit");
        $finish;
    end

endmodule
